### hw/rtl/ppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port pairing table package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int MAX_PORTS = 64;
    localparam int IDX_W     = $clog2(MAX_PORTS);
    localparam int CNT_W     = $clog2(MAX_PORTS + 1);
    localparam int NAME_W    = 32;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CUT    = 2'd1,
        OP_LINK   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NO_A = 2'd1,
        ST_NO_B = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KEY_NA,
        KEY_NB,
        KEY_ENT
    } key_sel_t;

    typedef enum logic [2:0] {
        WR_INSERT,
        WR_CLEAR_HIT,
        WR_CLEAR_A,
        WR_SET_A,
        WR_SET_B
    } wr_sel_t;

    typedef enum logic [1:0] {
        RPT_ZERO,
        RPT_ENTRY,
        RPT_INSERT,
        RPT_LINK
    } rpt_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_A,
        S_SRCH_B,
        S_RD_A,
        S_CHK_A,
        S_DROP_A,
        S_POST_A,
        S_CHK_B,
        S_DROP_B,
        S_SET_A,
        S_SET_B,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     srch_start;
        key_sel_t key_sel;
        logic     ins_we;
        logic     rd_en;
        logic     rd_b;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     load_a;
        logic     load_b;
        logic     out_load;
        rpt_sel_t rpt_sel;
        status_t  status;
    } dp_cmd_t;

    typedef struct packed {
        logic srch_done;
        logic srch_found;
        logic full;
        logic ent_valid;
        op_t  op;
    } dp_stat_t;

endpackage

### hw/rtl/port_pairing_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port pairing table
// Table of named ports with symmetric partner links: insert, cut, link, lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tdata carries name_a and name_b,
//   tuser carries the opcode and the partner_given flag. Each request gives
//   exactly one response on m_axis: tdata carries the partner name and the
//   link-present flag, tuser the status code.
// Sequencing:
//   One request is processed at a time. An insert needs no search; other
//   requests run linear searches over the occupied entries, one name per
//   cycle, and a link runs up to four. The next request is taken in the
//   cycle after the response is loaded.
// Reset:
//   rst_n clears the port count and the controller; the table holds no ports.
//   No memory clearing pass is needed.
// Stall:
//   A finished response waits in the output register while m_axis_tready is
//   low; the next request is still accepted and processed, and only its
//   result load waits until the register is free.
// ----------------------------------------------------------------------------
module port_pairing_table
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ppt_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // name_a, name_b
    input  logic [ppt_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // op, partner_given
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ppt_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // link_name, link_present, pad
    output logic [ppt_pkg::M_TUSER_W-1:0]      m_axis_tuser   // status
);

    ppt_pkg::dp_cmd_t   cmd;
    ppt_pkg::dp_stat_t  stat;
    logic [ppt_pkg::NAME_W-1:0] link_name;
    logic                       link_present;
    ppt_pkg::status_t           status;

    ppt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ppt_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_data      (s_axis_tdata),
        .in_user      (s_axis_tuser),
        .link_name    (link_name),
        .link_present (link_present),
        .status       (status)
    );

    assign m_axis_tdata = {{(ppt_pkg::M_TDATA_W - ppt_pkg::NAME_W - 1){1'b0}},
                           link_present, link_name};
    assign m_axis_tuser = status;

endmodule

### hw/rtl/ppt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port pairing table datapath
// Name and partner memories, linear search unit, request and result registers.
// ----------------------------------------------------------------------------
module ppt_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppt_pkg::dp_cmd_t                     cmd,
    output ppt_pkg::dp_stat_t                    stat,
    input  logic [ppt_pkg::S_TDATA_W-1:0]        in_data,
    input  logic [ppt_pkg::S_TUSER_W-1:0]        in_user,
    output logic [ppt_pkg::NAME_W-1:0]           link_name,
    output logic                                 link_present,
    output ppt_pkg::status_t                     status
);

    localparam int IDX_W  = ppt_pkg::IDX_W;
    localparam int CNT_W  = ppt_pkg::CNT_W;
    localparam int NAME_W = ppt_pkg::NAME_W;

    // Request registers
    ppt_pkg::op_t        op_reg;
    logic [NAME_W-1:0]   na_reg;
    logic [NAME_W-1:0]   nb_reg;
    logic                given_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [IDX_W-1:0]    b_idx_reg;

    // Memories: partner entry is {valid, name}
    logic [NAME_W-1:0]   names_mem [ppt_pkg::MAX_PORTS];
    logic [NAME_W:0]     pmem      [ppt_pkg::MAX_PORTS];
    logic [NAME_W:0]     ent_reg;

    // Search unit
    logic                srch_busy_reg;
    logic [CNT_W-1:0]    srch_ptr_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [NAME_W-1:0]   name_rd_reg;
    logic [NAME_W-1:0]   key_reg;
    logic [NAME_W-1:0]   key_next;
    logic                srch_done_reg;
    logic                srch_found_reg;
    logic [IDX_W-1:0]    srch_idx_reg;
    logic                hit;
    logic                exhausted;
    logic                issue;

    // Partner memory access
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [NAME_W:0]     wr_data;

    // Result registers
    logic [NAME_W-1:0]   link_name_reg;
    logic                link_present_reg;
    ppt_pkg::status_t    status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            na_reg    <= in_data[NAME_W-1:0];
            nb_reg    <= in_data[2*NAME_W-1:NAME_W];
            op_reg    <= ppt_pkg::op_t'(in_user[1:0]);
            given_reg <= in_user[2];
        end
        if (cmd.load_a)
        begin
            a_idx_reg <= srch_idx_reg;
        end
        if (cmd.load_b)
        begin
            b_idx_reg <= srch_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.ins_we)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.key_sel)
            ppt_pkg::KEY_NA:  key_next = na_reg;
            ppt_pkg::KEY_NB:  key_next = nb_reg;
            ppt_pkg::KEY_ENT: key_next = ent_reg[NAME_W-1:0];
            default:          key_next = na_reg;
        endcase
    end

    // Read one name per cycle, compare it in the next; first match wins
    assign hit       = cmp_vld_reg && (name_rd_reg == key_reg);
    assign exhausted = !cmp_vld_reg && (srch_ptr_reg >= count_reg);
    assign issue     = srch_busy_reg && (srch_ptr_reg < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_busy_reg  <= 1'b0;
            srch_ptr_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            srch_done_reg  <= 1'b0;
            srch_found_reg <= 1'b0;
        end
        else
        begin
            srch_done_reg <= 1'b0;
            if (cmd.srch_start)
            begin
                srch_busy_reg <= 1'b1;
                srch_ptr_reg  <= '0;
                cmp_vld_reg   <= 1'b0;
            end
            else if (srch_busy_reg)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    srch_ptr_reg <= srch_ptr_reg + 1'b1;
                end
                if (hit || exhausted)
                begin
                    srch_busy_reg  <= 1'b0;
                    srch_done_reg  <= 1'b1;
                    srch_found_reg <= hit;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.srch_start)
        begin
            key_reg <= key_next;
        end
        if (issue)
        begin
            cmp_idx_reg <= srch_ptr_reg[IDX_W-1:0];
        end
        if (srch_busy_reg && hit)
        begin
            srch_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_we)
        begin
            names_mem[count_reg[IDX_W-1:0]] <= na_reg;
        end
        if (issue)
        begin
            name_rd_reg <= names_mem[srch_ptr_reg[IDX_W-1:0]];
        end
    end

    assign rd_addr = cmd.rd_b ? b_idx_reg : a_idx_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            ppt_pkg::WR_INSERT:
            begin
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = {given_reg, given_reg ? nb_reg : '0};
            end
            ppt_pkg::WR_CLEAR_HIT:
            begin
                wr_addr = srch_idx_reg;
                wr_data = '0;
            end
            ppt_pkg::WR_CLEAR_A:
            begin
                wr_addr = a_idx_reg;
                wr_data = '0;
            end
            ppt_pkg::WR_SET_A:
            begin
                wr_addr = a_idx_reg;
                wr_data = {1'b1, nb_reg};
            end
            ppt_pkg::WR_SET_B:
            begin
                wr_addr = b_idx_reg;
                wr_data = {1'b1, na_reg};
            end
            default:
            begin
                wr_addr = a_idx_reg;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            pmem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            ent_reg <= pmem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.status;
            case (cmd.rpt_sel)
                ppt_pkg::RPT_ZERO:
                begin
                    link_name_reg    <= '0;
                    link_present_reg <= 1'b0;
                end
                ppt_pkg::RPT_ENTRY:
                begin
                    link_name_reg    <= ent_reg[NAME_W] ? ent_reg[NAME_W-1:0] : '0;
                    link_present_reg <= ent_reg[NAME_W];
                end
                ppt_pkg::RPT_INSERT:
                begin
                    link_name_reg    <= given_reg ? nb_reg : '0;
                    link_present_reg <= given_reg;
                end
                ppt_pkg::RPT_LINK:
                begin
                    link_name_reg    <= nb_reg;
                    link_present_reg <= 1'b1;
                end
                default:
                begin
                    link_name_reg    <= '0;
                    link_present_reg <= 1'b0;
                end
            endcase
        end
    end

    assign stat.srch_done  = srch_done_reg;
    assign stat.srch_found = srch_found_reg;
    assign stat.full       = (count_reg == CNT_W'(ppt_pkg::MAX_PORTS));
    assign stat.ent_valid  = ent_reg[NAME_W];
    assign stat.op         = op_reg;

    assign link_name    = link_name_reg;
    assign link_present = link_present_reg;
    assign status       = status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ppt_pkg::MAX_PORTS))
        else $error("port count beyond table size");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (srch_done_reg && srch_found_reg) |-> (CNT_W'(srch_idx_reg) < count_reg))
        else $error("search hit outside occupied entries");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_we |-> (count_reg < CNT_W'(ppt_pkg::MAX_PORTS)))
        else $error("insert into full table");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_we |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("port count did not advance on insert");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_start |-> !srch_busy_reg)
        else $error("search started while busy");

endmodule

### hw/rtl/ppt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port pairing table controller
// Sequences searches, partner reads and writes for each request.
// ----------------------------------------------------------------------------
module ppt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ppt_pkg::dp_cmd_t   cmd,
    input  ppt_pkg::dp_stat_t  stat
);

    ppt_pkg::state_t    state_reg;
    ppt_pkg::state_t    state_next;
    ppt_pkg::status_t   status_reg;
    ppt_pkg::status_t   status_next;
    ppt_pkg::rpt_sel_t  rpt_reg;
    ppt_pkg::rpt_sel_t  rpt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppt_pkg::S_IDLE;
            status_reg    <= ppt_pkg::ST_OK;
            rpt_reg       <= ppt_pkg::RPT_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            rpt_reg       <= rpt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        rpt_next       = rpt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        cmd            = '0;
        cmd.key_sel    = ppt_pkg::KEY_NA;
        cmd.wr_sel     = ppt_pkg::WR_INSERT;
        cmd.rpt_sel    = rpt_reg;
        cmd.status     = status_reg;

        case (state_reg)
            ppt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ppt_pkg::S_DISPATCH;
                end
            end

            ppt_pkg::S_DISPATCH:
            begin
                if (stat.op == ppt_pkg::OP_INSERT)
                begin
                    if (stat.full)
                    begin
                        status_next = ppt_pkg::ST_FULL;
                        rpt_next    = ppt_pkg::RPT_ZERO;
                    end
                    else
                    begin
                        cmd.ins_we  = 1'b1;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = ppt_pkg::WR_INSERT;
                        status_next = ppt_pkg::ST_OK;
                        rpt_next    = ppt_pkg::RPT_INSERT;
                    end
                    state_next = ppt_pkg::S_REPORT;
                end
                else
                begin
                    cmd.srch_start = 1'b1;
                    cmd.key_sel    = ppt_pkg::KEY_NA;
                    state_next     = ppt_pkg::S_SRCH_A;
                end
            end

            ppt_pkg::S_SRCH_A:
            begin
                if (stat.srch_done)
                begin
                    if (!stat.srch_found)
                    begin
                        status_next = ppt_pkg::ST_NO_A;
                        rpt_next    = ppt_pkg::RPT_ZERO;
                        state_next  = ppt_pkg::S_REPORT;
                    end
                    else
                    begin
                        cmd.load_a = 1'b1;
                        if (stat.op == ppt_pkg::OP_LINK)
                        begin
                            cmd.srch_start = 1'b1;
                            cmd.key_sel    = ppt_pkg::KEY_NB;
                            state_next     = ppt_pkg::S_SRCH_B;
                        end
                        else
                        begin
                            state_next = ppt_pkg::S_RD_A;
                        end
                    end
                end
            end

            ppt_pkg::S_SRCH_B:
            begin
                if (stat.srch_done)
                begin
                    if (!stat.srch_found)
                    begin
                        status_next = ppt_pkg::ST_NO_B;
                        rpt_next    = ppt_pkg::RPT_ZERO;
                        state_next  = ppt_pkg::S_REPORT;
                    end
                    else
                    begin
                        cmd.load_b = 1'b1;
                        state_next = ppt_pkg::S_RD_A;
                    end
                end
            end

            ppt_pkg::S_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ppt_pkg::S_CHK_A;
            end

            ppt_pkg::S_CHK_A:
            begin
                if (stat.op == ppt_pkg::OP_LOOKUP)
                begin
                    status_next = ppt_pkg::ST_OK;
                    rpt_next    = ppt_pkg::RPT_ENTRY;
                    state_next  = ppt_pkg::S_REPORT;
                end
                else if (stat.ent_valid)
                begin
                    cmd.srch_start = 1'b1;
                    cmd.key_sel    = ppt_pkg::KEY_ENT;
                    state_next     = ppt_pkg::S_DROP_A;
                end
                else
                begin
                    state_next = ppt_pkg::S_POST_A;
                end
            end

            ppt_pkg::S_DROP_A:
            begin
                // an old partner that is not in the table is skipped
                if (stat.srch_done)
                begin
                    cmd.wr_en  = stat.srch_found;
                    cmd.wr_sel = ppt_pkg::WR_CLEAR_HIT;
                    state_next = ppt_pkg::S_POST_A;
                end
            end

            ppt_pkg::S_POST_A:
            begin
                if (stat.op == ppt_pkg::OP_CUT)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = ppt_pkg::WR_CLEAR_A;
                    status_next = ppt_pkg::ST_OK;
                    rpt_next    = ppt_pkg::RPT_ZERO;
                    state_next  = ppt_pkg::S_REPORT;
                end
                else
                begin
                    // read B only after A's old partner is cleared
                    cmd.rd_en  = 1'b1;
                    cmd.rd_b   = 1'b1;
                    state_next = ppt_pkg::S_CHK_B;
                end
            end

            ppt_pkg::S_CHK_B:
            begin
                if (stat.ent_valid)
                begin
                    cmd.srch_start = 1'b1;
                    cmd.key_sel    = ppt_pkg::KEY_ENT;
                    state_next     = ppt_pkg::S_DROP_B;
                end
                else
                begin
                    state_next = ppt_pkg::S_SET_A;
                end
            end

            ppt_pkg::S_DROP_B:
            begin
                if (stat.srch_done)
                begin
                    cmd.wr_en  = stat.srch_found;
                    cmd.wr_sel = ppt_pkg::WR_CLEAR_HIT;
                    state_next = ppt_pkg::S_SET_A;
                end
            end

            ppt_pkg::S_SET_A:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ppt_pkg::WR_SET_A;
                state_next = ppt_pkg::S_SET_B;
            end

            ppt_pkg::S_SET_B:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ppt_pkg::WR_SET_B;
                status_next = ppt_pkg::ST_OK;
                rpt_next    = ppt_pkg::RPT_LINK;
                state_next  = ppt_pkg::S_REPORT;
            end

            ppt_pkg::S_REPORT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ppt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ppt_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
